>>> sv/csv_field_tokenizer_assert.svh
// Assertion macros used by the checker file of the CSV field tokenizer.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define CFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/cft_pkg.sv
// Package with types, constants and helper functions of the CSV field tokenizer.
package cft_pkg;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INTEGER = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DECIMAL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUOTED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PLAIN   = 3'd4;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DELIMITER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEWLINE   = 2'd2;

   localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'd44;
   localparam logic [BYTE_W-1:0] QUOTE_RESET     = 8'd34;
   localparam logic [BYTE_W-1:0] NEWLINE_RESET   = 8'd10;

   localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'h2D;
   localparam logic [BYTE_W-1:0] DOT_BYTE   = 8'h2E;
   localparam logic [BYTE_W-1:0] DIGIT_LOW  = 8'h30;
   localparam logic [BYTE_W-1:0] DIGIT_HIGH = 8'h39;

   typedef struct packed {
      logic [BYTE_W-1:0] delimiter_char;
      logic [BYTE_W-1:0] quote_char;
      logic [BYTE_W-1:0] newline_char;
   } cft_cfg_type;

   typedef struct packed {
      logic inside_quotes;
      logic quoted_field;
      logic may_be_integer;
      logic may_be_decimal;
      logic field_nonempty;
      logic error_seen;
   } cft_state_type;

   localparam cft_state_type STATE_RESET = '{
      inside_quotes:  1'b0,
      quoted_field:   1'b0,
      may_be_integer: 1'b1,
      may_be_decimal: 1'b1,
      field_nonempty: 1'b0,
      error_seen:     1'b0
   };

   typedef struct packed {
      logic              byte_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              field_end;
      logic [KIND_W-1:0] field_kind;
      logic              row_end;
      logic              parse_error;
   } cft_rsp_type;

   function automatic logic [KIND_W-1:0] kind_of(input cft_state_type st);
      logic [KIND_W-1:0] kind;
      if (!st.field_nonempty) begin
         kind = KIND_EMPTY;
      end else if (st.may_be_integer) begin
         kind = KIND_INTEGER;
      end else if (st.may_be_decimal) begin
         kind = KIND_DECIMAL;
      end else if (st.quoted_field) begin
         kind = KIND_QUOTED;
      end else begin
         kind = KIND_PLAIN;
      end
      return kind;
   endfunction

endpackage

>>> sv/cft_req_if.sv
// Interface of the input channel: one content byte or an end-of-content beat.
interface cft_req_if import cft_pkg::*;;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

>>> sv/cft_rsp_if.sv
// Interface of the result channel: one output byte and field report per beat.
interface cft_rsp_if import cft_pkg::*;;
   logic              valid;
   logic              ready;
   logic              byte_valid;
   logic [BYTE_W-1:0] out_byte;
   logic              field_end;
   logic [KIND_W-1:0] field_kind;
   logic              row_end;
   logic              parse_error;

   modport source (output valid, output byte_valid, output out_byte, output field_end,
                   output field_kind, output row_end, output parse_error, input ready);
   modport sink   (input valid, input byte_valid, input out_byte, input field_end,
                   input field_kind, input row_end, input parse_error, output ready);
endinterface

>>> sv/cft_csr.sv
// Configuration registers for the delimiter, quote and newline bytes.
module cft_csr import cft_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   output cft_cfg_type          cfg
);

   cft_cfg_type cfg_ff;
   cft_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DELIMITER: cfg_in.delimiter_char = csr_wdata;
            CSR_QUOTE:     cfg_in.quote_char     = csr_wdata;
            CSR_NEWLINE:   cfg_in.newline_char   = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter_char <= DELIMITER_RESET;
         cfg_ff.quote_char     <= QUOTE_RESET;
         cfg_ff.newline_char   <= NEWLINE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/cft_parse.sv
// Field state flags and the per-beat tokenizing logic.
module cft_parse import cft_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              req_type,
   input  logic [BYTE_W-1:0] data_byte,
   input  cft_cfg_type       cfg,
   output cft_rsp_type       rsp
);

   cft_state_type st_ff;
   cft_state_type st_in;
   cft_rsp_type   res;
   logic          is_delim;
   logic          is_newline;
   logic          is_quote;
   logic          is_digit;
   logic          first;
   logic          quoted_now;

   always_comb begin
      is_delim   = (data_byte == cfg.delimiter_char);
      is_newline = (data_byte == cfg.newline_char);
      is_quote   = (data_byte == cfg.quote_char);
      is_digit   = (data_byte >= DIGIT_LOW) && (data_byte <= DIGIT_HIGH);
      first      = !st_ff.field_nonempty;
      quoted_now = st_ff.quoted_field || first;
      st_in      = st_ff;
      res        = '0;
      if (req_type == REQ_END) begin
         res.field_end   = 1'b1;
         res.row_end     = 1'b1;
         res.field_kind  = kind_of(st_ff);
         res.parse_error = st_ff.error_seen || st_ff.inside_quotes;
         st_in           = STATE_RESET;
      end else if (!st_ff.inside_quotes && (is_delim || is_newline)) begin
         res.field_end        = 1'b1;
         res.field_kind       = kind_of(st_ff);
         res.row_end          = is_newline;
         st_in.quoted_field   = 1'b0;
         st_in.may_be_integer = 1'b1;
         st_in.may_be_decimal = 1'b1;
         st_in.field_nonempty = 1'b0;
      end else if (st_ff.quoted_field && !st_ff.inside_quotes && !is_quote) begin
         st_in.error_seen = 1'b1;
      end else begin
         if (is_quote) begin
            st_in.quoted_field = quoted_now;
            if (quoted_now) begin
               st_in.inside_quotes = !st_ff.inside_quotes;
               // A quote that reopens right after a closing one is an escaped quote.
               res.byte_valid = !first && !st_ff.inside_quotes;
            end else begin
               res.byte_valid = 1'b1;
            end
         end else begin
            res.byte_valid = 1'b1;
         end
         res.out_byte = res.byte_valid ? data_byte : '0;
         if (st_ff.may_be_decimal && !is_digit &&
             (st_ff.field_nonempty || data_byte != MINUS_BYTE)) begin
            if (data_byte == DOT_BYTE) begin
               if (st_ff.may_be_integer) begin
                  st_in.may_be_integer = 1'b0;
               end else begin
                  st_in.may_be_decimal = 1'b0;
               end
            end else begin
               st_in.may_be_integer = 1'b0;
               st_in.may_be_decimal = 1'b0;
            end
         end
         st_in.field_nonempty = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   assign rsp = res;

endmodule

>>> sv/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: input register, tokenizing step, result register.
// Each result is registered after the tokenizing step; one beat per cycle is sustained
// while the result channel does not stall.
// While a result waits, the block takes at most one more beat, into its empty input register.
// Synchronous active-high reset returns the field state flags to their idle values and
// restores the default delimiter, quote and newline bytes; no clearing pass is needed.
module csv_field_tokenizer import cft_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   cft_req_if.sink              req_chan,
   cft_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   cft_cfg_type       cfg;
   cft_rsp_type       step_rsp;
   logic              in_valid_ff;
   logic              in_type_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   cft_rsp_type       out_ff;
   logic              advance;
   logic              req_take;

   cft_csr u_cft_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cft_parse u_cft_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_type  (in_type_ff),
      .data_byte (in_byte_ff),
      .cfg       (cfg),
      .rsp       (step_rsp)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff <= req_chan.req_type;
         in_byte_ff <= req_chan.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.byte_valid  = out_ff.byte_valid;
   assign rsp_chan.out_byte    = out_ff.out_byte;
   assign rsp_chan.field_end   = out_ff.field_end;
   assign rsp_chan.field_kind  = out_ff.field_kind;
   assign rsp_chan.row_end     = out_ff.row_end;
   assign rsp_chan.parse_error = out_ff.parse_error;

endmodule

>>> sv/cft_checker.sv
// Port-level checker of the CSV field tokenizer and its bind to the top level.
`include "csv_field_tokenizer_assert.svh"

module cft_checker import cft_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              byte_valid,
   input logic [BYTE_W-1:0] out_byte,
   input logic              field_end,
   input logic [KIND_W-1:0] field_kind,
   input logic              row_end,
   input logic              parse_error
);

   `CFT_ASSERT_NOW(a_byte_xor_field, clock, reset, rsp_valid, !(byte_valid && field_end))
   `CFT_ASSERT_NOW(a_kind_only_at_end, clock, reset, rsp_valid && !field_end,
                   field_kind == KIND_EMPTY && !row_end)
   `CFT_ASSERT_NOW(a_error_at_row_end, clock, reset, rsp_valid && parse_error,
                   field_end && row_end && !byte_valid)
   `CFT_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(out_byte) && $stable(field_kind))

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .byte_valid  (rsp_chan.byte_valid),
   .out_byte    (rsp_chan.out_byte),
   .field_end   (rsp_chan.field_end),
   .field_kind  (rsp_chan.field_kind),
   .row_end     (rsp_chan.row_end),
   .parse_error (rsp_chan.parse_error)
);
